// ===== design/jbt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the JSON byte tokenizer.
// No dependencies; used by jbt_tok_if, the top level, the checker and the testbench.
package jbt_pkg;

	localparam int LINE_BITS   = 20;
	localparam int COLUMN_BITS = 16;

	// result queue depth; two words may enter per byte
	localparam int QDEPTH = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	localparam logic [7:0] CHR_LBRACE  = 8'h7B;
	localparam logic [7:0] CHR_RBRACE  = 8'h7D;
	localparam logic [7:0] CHR_LBRACK  = 8'h5B;
	localparam logic [7:0] CHR_RBRACK  = 8'h5D;
	localparam logic [7:0] CHR_COLON   = 8'h3A;
	localparam logic [7:0] CHR_COMMA   = 8'h2C;
	localparam logic [7:0] CHR_QUOTE   = 8'h22;
	localparam logic [7:0] CHR_BSLASH  = 8'h5C;
	localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
	localparam logic [7:0] CHR_NEWLINE = 8'h0A;

	typedef enum logic [2:0] {
		MODE_PLAIN  = 3'b001,
		MODE_STRING = 3'b010,
		MODE_NUMBER = 3'b100
	} lex_mode_t;

	typedef struct packed {
		logic                   has_byte;
		logic [7:0]             lexeme_byte;
		logic                   token_end;
		logic [LINE_BITS-1:0]   line_number;
		logic [COLUMN_BITS-1:0] column_number;
	} res_t;

endpackage

// ===== design/jbt_byte_if.sv =====
`timescale 1ns / 1ps
// Input channel: one raw JSON byte per word, valid/ready handshake.
// Depends on nothing.
interface jbt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// ===== design/jbt_tok_if.sv =====
`timescale 1ns / 1ps
// Output channel: one lexeme byte or end mark per word, with position.
// Widths come from jbt_pkg.
interface jbt_tok_if;
	logic                           valid;
	logic                           ready;
	logic                           has_byte;
	logic [7:0]                     lexeme_byte;
	logic                           token_end;
	logic [jbt_pkg::LINE_BITS-1:0]   line_number;
	logic [jbt_pkg::COLUMN_BITS-1:0] column_number;

	modport source (output valid, output has_byte, output lexeme_byte, output token_end,
		output line_number, output column_number, input ready);
	modport sink (input valid, input has_byte, input lexeme_byte, input token_end,
		input line_number, input column_number, output ready);
endinterface

// ===== design/json_byte_tokenizer.sv =====
`timescale 1ns / 1ps
// JSON byte tokenizer top level.
// Depends on jbt_pkg, jbt_byte_if and jbt_tok_if.
//
// Usage:
//   byte_in takes one JSON text byte per word. tok_out gives lexeme words:
//   a byte of a token (has_byte 1) or a bare end mark (has_byte 0,
//   token_end 1), each with the saturating line and column position.
//   A byte yields zero, one or two words; two when a string or number is
//   closed by a byte that is then emitted as a token of its own.
// Path: a byte is held in the input register, then its words are written
//   into the result queue, which drives tok_out.
// Throughput: one byte per cycle while the result queue has room. The byte
//   register drains into a four-word result queue when at least two slots are
//   free. A consumer that takes one word per cycle holds the input back only
//   when words outrun bytes, as when bytes give two words each.
// Stall: when tok_out is not taken the queue fills and byte_in.ready drops
//   once the byte register holds a word that cannot drain. Nothing is lost.
// Reset: arst_n clears the mode, flags, position counters and the queue.
module json_byte_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	jbt_byte_if.sink    byte_in,
	jbt_tok_if.source   tok_out
);
	import jbt_pkg::*;

	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
	localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

	logic                   v_s1;
	logic [7:0]             byte_s1;
	lex_mode_t              mode_q, mode_d;
	logic                   after_str_q, after_str_d;
	logic                   esc_q, esc_d;
	logic                   nonempty_q, nonempty_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [COLUMN_BITS-1:0] col_q, col_d;

	res_t                   queue_q [QDEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0]   cnt_q;

	logic room, push, pop, accept;
	logic close_emit, main_emit;
	logic [7:0] main_byte;
	logic main_end;
	logic [1:0] push_n;
	res_t r_close, r_main;
	logic [LINE_BITS-1:0]   line_cnt;
	logic [COLUMN_BITS-1:0] col_cnt;
	logic is_nl, is_struct, is_digit;

	assign room   = cnt_q <= QCNT_BITS'(QDEPTH - 2);
	assign push   = v_s1 && room;
	assign pop    = tok_out.valid && tok_out.ready;
	assign accept = byte_in.valid && byte_in.ready;
	assign byte_in.ready = !v_s1 || room;

	// byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (room) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= byte_in.in_byte;
		end
	end

	// position after counting the byte
	always_comb begin
		is_nl     = byte_s1 == CHR_NEWLINE;
		is_struct = byte_s1 inside {CHR_LBRACE, CHR_RBRACE, CHR_LBRACK, CHR_RBRACK,
			CHR_COLON, CHR_COMMA};
		is_digit  = byte_s1 inside {[CHR_DIGIT_0:CHR_DIGIT_9]};
		if (is_nl) begin
			col_cnt  = '0;
			line_cnt = (line_q != LINE_MAX) ? line_q + 1'b1 : line_q;
		end else begin
			line_cnt = line_q;
			col_cnt  = (col_q != COL_MAX) ? col_q + 1'b1 : col_q;
		end
	end

	// one lexer step
	always_comb begin
		mode_d      = mode_q;
		after_str_d = after_str_q;
		esc_d       = esc_q;
		nonempty_d  = nonempty_q;
		line_d      = line_cnt;
		col_d       = col_cnt;
		close_emit  = 1'b0;
		main_emit   = 1'b0;
		main_byte   = byte_s1;
		main_end    = 1'b0;
		case (mode_q)
			MODE_STRING: begin
				if (!esc_q && byte_s1 == CHR_BSLASH) begin
					esc_d = 1'b1;
				end else if (!esc_q && byte_s1 == CHR_QUOTE) begin
					// close, then re-read the quote as a token; this clears after_string
					close_emit  = nonempty_q;
					nonempty_d  = 1'b0;
					mode_d      = MODE_PLAIN;
					after_str_d = 1'b0;
					main_emit   = 1'b1;
					main_end    = 1'b1;
				end else begin
					esc_d      = 1'b0;
					nonempty_d = 1'b1;
					main_emit  = 1'b1;
				end
			end
			MODE_NUMBER: begin
				if (byte_s1 == CHR_COMMA || byte_s1 == CHR_RBRACE) begin
					close_emit  = nonempty_q;
					nonempty_d  = 1'b0;
					mode_d      = MODE_PLAIN;
					after_str_d = 1'b0;
					main_emit   = 1'b1;
					main_end    = 1'b1;
				end else begin
					nonempty_d = 1'b1;
					main_emit  = 1'b1;
				end
			end
			default: begin
				mode_d = MODE_PLAIN;
				if (is_struct) begin
					main_emit = 1'b1;
					main_end  = 1'b1;
				end else if (byte_s1 == CHR_QUOTE) begin
					main_emit = 1'b1;
					main_end  = 1'b1;
					if (after_str_q) begin
						after_str_d = 1'b0;
					end else begin
						mode_d = MODE_STRING;
						esc_d  = 1'b0;
					end
				end else if (is_digit) begin
					mode_d      = MODE_NUMBER;
					after_str_d = 1'b0;
					nonempty_d  = 1'b1;
					main_emit   = 1'b1;
				end
			end
		endcase

		// end mark carries the position before the byte is counted
		r_close.has_byte      = 1'b0;
		r_close.lexeme_byte   = '0;
		r_close.token_end     = 1'b1;
		r_close.line_number   = line_q;
		r_close.column_number = col_q;
		r_main.has_byte       = 1'b1;
		r_main.lexeme_byte    = main_byte;
		r_main.token_end      = main_end;
		r_main.line_number    = line_cnt;
		r_main.column_number  = col_cnt;
		push_n = {1'b0, close_emit} + {1'b0, main_emit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_PLAIN;
			after_str_q <= 1'b0;
			esc_q       <= 1'b0;
			nonempty_q  <= 1'b0;
			line_q      <= '0;
			col_q       <= '0;
		end else if (push) begin
			mode_q      <= mode_d;
			after_str_q <= after_str_d;
			esc_q       <= esc_d;
			nonempty_q  <= nonempty_d;
			line_q      <= line_d;
			col_q       <= col_d;
		end
	end

	// result queue: up to two words in, one word out per cycle while tok_out is ready
	always_ff @(posedge clk) begin
		if (push) begin
			if (close_emit) begin
				queue_q[wr_ptr_q] <= r_close;
				if (main_emit) begin
					queue_q[wr_ptr_q + 1'b1] <= r_main;
				end
			end else if (main_emit) begin
				queue_q[wr_ptr_q] <= r_main;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (push ? QCNT_BITS'(push_n) : '0) - QCNT_BITS'(pop);
		end
	end

	assign tok_out.valid         = cnt_q != '0;
	assign tok_out.has_byte      = queue_q[rd_ptr_q].has_byte;
	assign tok_out.lexeme_byte   = queue_q[rd_ptr_q].lexeme_byte;
	assign tok_out.token_end     = queue_q[rd_ptr_q].token_end;
	assign tok_out.line_number   = queue_q[rd_ptr_q].line_number;
	assign tok_out.column_number = queue_q[rd_ptr_q].column_number;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_BITS'(QDEPTH))
		else $error("result queue overfilled");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> cnt_q == $past(cnt_q) + ($past(push) ? QCNT_BITS'($past(push_n)) : '0)
			- QCNT_BITS'($past(pop)))
		else $error("queue count out of step with push and pop");

	a_bare_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		tok_out.valid && !tok_out.has_byte |-> tok_out.token_end)
		else $error("word without a byte is not an end mark");

	a_esc_in_string: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> mode_q == MODE_STRING)
		else $error("escape pending outside a string");

	a_nonempty_open: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty_q |-> mode_q != MODE_PLAIN)
		else $error("open token bytes in plain mode");
`endif

endmodule

// ===== dv/jbt_lexeme_checker.sv =====
`timescale 1ns / 1ps
// Lexeme checker for the JSON byte tokenizer: watches both channels,
// predicts each token word and compares it. Depends on jbt_pkg and the two channel interfaces.
module jbt_lexeme_checker (
	input  logic               clk,
	input  logic               arst_n,
	jbt_byte_if                byte_mon,
	jbt_tok_if                 tok_mon,
	output int                 fail_count,
	output int                 words_left,
	output jbt_pkg::lex_mode_t mode_now
);
	import jbt_pkg::*;

	localparam int MAX_REPORTS = 40;

	lex_mode_t              mode_q;
	logic                   after_string_q;
	logic                   escape_pending_q;
	logic                   token_open_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [COLUMN_BITS-1:0] column_q;
	res_t                   expected_words[$];

	initial begin
		fail_count = 0;
		words_left = 0;
		mode_now = MODE_PLAIN;
	end

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		if (fail_count < MAX_REPORTS)
			$display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic void advance_position(logic [7:0] b);
		if (b == CHR_NEWLINE) begin
			column_q = '0;
			if (line_q != '1)
				line_q++;
		end else if (column_q != '1) begin
			column_q++;
		end
	endfunction

	function automatic void push_word(logic has, logic [7:0] b, logic fin);
		res_t w;
		w.has_byte = has;
		w.lexeme_byte = b;
		w.token_end = fin;
		w.line_number = line_q;
		w.column_number = column_q;
		expected_words.push_back(w);
	endfunction

	function automatic void append_byte(logic [7:0] b);
		advance_position(b);
		token_open_q = 1'b1;
		push_word(1'b1, b, 1'b0);
	endfunction

	// bare end mark, only for a token that holds bytes
	function automatic void close_lexeme();
		if (token_open_q)
			push_word(1'b0, 8'h00, 1'b1);
		token_open_q = 1'b0;
	endfunction

	function automatic void plain_byte(logic [7:0] b);
		advance_position(b);
		case (b)
			CHR_LBRACE, CHR_RBRACE, CHR_LBRACK, CHR_RBRACK, CHR_COLON, CHR_COMMA: begin
				push_word(1'b1, b, 1'b1);
			end
			CHR_QUOTE: begin
				push_word(1'b1, b, 1'b1);
				// the closing quote of a string comes back here and opens nothing
				if (after_string_q) begin
					after_string_q = 1'b0;
				end else begin
					mode_q = MODE_STRING;
					escape_pending_q = 1'b0;
				end
			end
			default: begin
				if (b >= CHR_DIGIT_0 && b <= CHR_DIGIT_9) begin
					mode_q = MODE_NUMBER;
					after_string_q = 1'b0;
					token_open_q = 1'b1;
					push_word(1'b1, b, 1'b0);
				end
			end
		endcase
	endfunction

	function automatic void tokenize_byte(logic [7:0] b);
		case (mode_q)
			MODE_STRING: begin
				if (!escape_pending_q && b == CHR_BSLASH) begin
					advance_position(b);
					escape_pending_q = 1'b1;
				end else if (!escape_pending_q && b == CHR_QUOTE) begin
					close_lexeme();
					mode_q = MODE_PLAIN;
					after_string_q = 1'b1;
					plain_byte(b);
				end else begin
					escape_pending_q = 1'b0;
					append_byte(b);
				end
			end
			MODE_NUMBER: begin
				if (b == CHR_COMMA || b == CHR_RBRACE) begin
					close_lexeme();
					mode_q = MODE_PLAIN;
					after_string_q = 1'b0;
					plain_byte(b);
				end else begin
					append_byte(b);
				end
			end
			default: begin
				mode_q = MODE_PLAIN;
				plain_byte(b);
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t seen;
		res_t want;
		if (!arst_n) begin
			mode_q = MODE_PLAIN;
			after_string_q = 1'b0;
			escape_pending_q = 1'b0;
			token_open_q = 1'b0;
			line_q = '0;
			column_q = '0;
			expected_words.delete();
		end else begin
			if (byte_mon.valid && byte_mon.ready)
				tokenize_byte(byte_mon.in_byte);
			if (tok_mon.valid && tok_mon.ready) begin
				seen.has_byte = tok_mon.has_byte;
				seen.lexeme_byte = tok_mon.lexeme_byte;
				seen.token_end = tok_mon.token_end;
				seen.line_number = tok_mon.line_number;
				seen.column_number = tok_mon.column_number;
				if (expected_words.size() == 0) begin
					report_mismatch("word with nothing expected", seen, 0);
				end else begin
					want = expected_words.pop_front();
					if (seen.has_byte !== want.has_byte)
						report_mismatch("has_byte", seen.has_byte, want.has_byte);
					if (seen.lexeme_byte !== want.lexeme_byte)
						report_mismatch("lexeme_byte", seen.lexeme_byte, want.lexeme_byte);
					if (seen.token_end !== want.token_end)
						report_mismatch("token_end", seen.token_end, want.token_end);
					if (seen.line_number !== want.line_number)
						report_mismatch("line_number", seen.line_number, want.line_number);
					if (seen.column_number !== want.column_number)
						report_mismatch("column_number", seen.column_number,
							want.column_number);
				end
			end
		end
		words_left = expected_words.size();
		mode_now = mode_q;
	end

endmodule

// ===== dv/json_byte_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for json_byte_tokenizer: byte stimulus, random idling, verdict.
// Depends on jbt_pkg, both channel interfaces, the block and jbt_lexeme_checker.
module json_byte_tokenizer_tb;
	import jbt_pkg::*;

	localparam int RANDOM_BYTES = 600;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n;

	jbt_byte_if byte_ch ();
	jbt_tok_if  tok_ch ();

	int        fail_count;
	int        words_left;
	lex_mode_t mode_now;

	logic [7:0]  text_q[$];
	int          pushed = 0;
	int          accepted;
	int          quiet;
	bit          calm = 1'b0;
	int unsigned src_gap, sink_gap;
	int unsigned src_pct = 0;
	int unsigned sink_pct = 0;

	json_byte_tokenizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_in(byte_ch),
		.tok_out(tok_ch)
	);

	jbt_lexeme_checker lexeme_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_mon  (byte_ch),
		.tok_mon   (tok_ch),
		.fail_count(fail_count),
		.words_left(words_left),
		.mode_now  (mode_now)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// change idle density now and then; zero gives stretches with no idling
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			src_pct <= $urandom_range(0, 3) * 10;
		if ($urandom_range(0, 199) == 0)
			sink_pct <= $urandom_range(0, 3) * 10;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			byte_ch.in_byte <= '0;
			src_gap <= 0;
		end else if (!byte_ch.valid || byte_ch.ready) begin
			if (src_gap != 0) begin
				byte_ch.valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (!calm && $urandom_range(0, 99) < src_pct) begin
				byte_ch.valid <= 1'b0;
				src_gap <= $urandom_range(1, 17) - 1;
			end else if (text_q.size() != 0) begin
				byte_ch.valid <= 1'b1;
				byte_ch.in_byte <= text_q.pop_front();
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ch.ready <= 1'b1;
			sink_gap <= 0;
		end else if (sink_gap != 0) begin
			tok_ch.ready <= 1'b0;
			sink_gap <= sink_gap - 1;
		end else if (!calm && $urandom_range(0, 99) < sink_pct) begin
			tok_ch.ready <= 1'b0;
			sink_gap <= $urandom_range(1, 17) - 1;
		end else begin
			tok_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			accepted <= 0;
		else if (byte_ch.valid && byte_ch.ready)
			accepted <= accepted + 1;
	end

	// count cycles with no word moving on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet <= 0;
		end else if ((byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_byte(logic [7:0] b);
		text_q.push_back(b);
		pushed++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic drain_words();
		wait (accepted == pushed);
		wait (words_left == 0);
	endtask

	initial begin
		int random_start;
		byte_ch.valid = 1'b0;
		byte_ch.in_byte = '0;
		tok_ch.ready = 1'b1;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// byte extremes and a stray backslash in plain mode, all dropped
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CHR_BSLASH);
		// string with escaped quote and backslash, number holding a bracket
		send_text("{\"a\\\"\\\\\":[09],");
		// empty string, newlines, number closed by a brace
		send_text("\"\"\n7\n}");
		// string holding a newline and both byte extremes
		send_text("\"\n");
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(CHR_QUOTE);
		drain_words();

		random_start = pushed;
		while (pushed < random_start + RANDOM_BYTES) begin
			int unsigned n;
			logic [7:0]  c;
			case ($urandom_range(0, 9))
				0, 1: begin
					send_byte(CHR_QUOTE);
					n = $urandom_range(0, 6);
					repeat (n) begin
						c = 8'($urandom_range(0, 255));
						if (c == CHR_QUOTE || c == CHR_BSLASH || $urandom_range(0, 5) == 0)
							send_byte(CHR_BSLASH);
						send_byte(c);
					end
					send_byte(CHR_QUOTE);
				end
				2, 3: begin
					send_byte(CHR_DIGIT_0 + 8'($urandom_range(0, 9)));
					n = $urandom_range(0, 4);
					repeat (n) begin
						case ($urandom_range(0, 15))
							0: send_byte("-");
							1: send_byte(".");
							2: send_byte("e");
							3: send_byte(8'h20);
							4: send_byte(CHR_NEWLINE);
							5: send_byte(CHR_RBRACK);
							default: send_byte(CHR_DIGIT_0 + 8'($urandom_range(0, 9)));
						endcase
					end
					n = $urandom_range(0, 19);
					if (n < 14)
						send_byte(CHR_COMMA);
					else if (n < 19)
						send_byte(CHR_RBRACE);
				end
				4: begin
					case ($urandom_range(0, 5))
						0: send_byte(CHR_LBRACE);
						1: send_byte(CHR_RBRACE);
						2: send_byte(CHR_LBRACK);
						3: send_byte(CHR_RBRACK);
						4: send_byte(CHR_COLON);
						default: send_byte(CHR_COMMA);
					endcase
				end
				5: begin
					case ($urandom_range(0, 3))
						0: send_byte(8'h20);
						1: send_byte(8'h09);
						2: send_byte(8'h0D);
						default: send_byte(CHR_NEWLINE);
					endcase
				end
				6: begin
					send_byte(CHR_QUOTE);
					n = $urandom_range(1, 4);
					repeat (n) send_byte("a" + 8'($urandom_range(0, 25)));
					send_byte(CHR_QUOTE);
					send_byte(CHR_COLON);
				end
				7: send_byte(8'($urandom_range(0, 255)));
				8: begin
					// broken sequence: open a string and leave it open
					send_byte(CHR_QUOTE);
					n = $urandom_range(1, 3);
					repeat (n) send_byte(8'($urandom_range(0, 255)));
				end
				default: begin
					send_byte(CHR_QUOTE);
					send_byte(CHR_BSLASH);
					send_byte(CHR_QUOTE);
					send_byte(CHR_QUOTE);
				end
			endcase
		end
		drain_words();

		// return to plain mode whatever the random part left open
		calm = 1'b1;
		case (mode_now)
			MODE_STRING: send_text("a\"");
			MODE_NUMBER: send_byte(CHR_COMMA);
			default: ;
		endcase
		// a few tokens back to back with no idling
		send_text("[12,\"ab\"]\n}");

		drain_words();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && words_left == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
